// ===== rtl/xder_pkg.sv =====
`default_nettype none

package xder_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_LENGTH_BITS       = 16;
    localparam int DEF_KEY_POINT_BYTES   = 65;
    localparam int DEF_MAX_LENGTH_OCTETS = 8;

    // DER tags and fixed byte values.
    localparam logic [7:0] TAG_SEQ    = 8'h30;
    localparam logic [7:0] TAG_CTX0   = 8'hA0;
    localparam logic [7:0] TAG_CTX3   = 8'hA3;
    localparam logic [7:0] TAG_BITS   = 8'h03;
    localparam logic [7:0] TAG_INT    = 8'h02;
    localparam logic [7:0] POINT_FORM = 8'h04;

    // Number of plain SEQUENCEs between the serial number and the SPKI.
    localparam logic [2:0] TBS_SEQ_COUNT = 3'd4;

    // Depth of the result queue.
    localparam int RES_FIFO_DEPTH = 4;

    typedef logic [3:0] t_octets;
    typedef logic [2:0] t_tbs_count;
    typedef logic [6:0] t_key_index;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_TAG   = 3'd1,
        ST_LEN   = 3'd2,
        ST_SIZE  = 3'd3,
        ST_KEY   = 3'd4,
        ST_TRUNC = 3'd5
    } t_status;

    // One result word.
    typedef struct packed {
        logic       is_status;
        logic [7:0] key_byte;
        t_key_index key_index;
        t_status    status;
        logic       end_of_run;
    } t_result;

    // Results produced by one accepted byte: a key word, then a status word.
    typedef struct packed {
        logic    key_vld;
        t_result key;
        logic    stat_vld;
        t_result stat;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/x509_der_public_key_extractor_core.sv =====
// Streams a DER certificate in one byte per word and checks its shape while
// passing out the bytes of the subject public point as they arrive.
// Input channel: i_valid / o_stall carry i_data_byte and i_last_byte; a word
// moves when i_valid is high and o_stall is low. i_last_byte marks the final
// byte of a certificate.
// Output channel: o_valid / i_stall carry one result word: a key word
// (o_is_status low, o_key_byte at o_key_index) or, after the final byte, a
// status word (o_is_status and o_end_of_run high, o_status). Key words count
// only when the following status is ok.
// Throughput is one byte per cycle while o_stall is low: the parser updates
// its state in the cycle a byte is accepted. Results enter a four-word queue
// that drains one word per cycle while i_stall is low. A final byte that is
// also a key byte yields two words, so o_stall rises while the queue holds
// more than two words. When the receiver stalls, the queue fills and o_stall
// holds the sender off; nothing is lost and a stalled word does not change.
// Reset clears the parser to expect a new certificate and empties the queue.
`default_nettype none

module x509_der_public_key_extractor_core #(
    parameter int LENGTH_BITS       = xder_pkg::DEF_LENGTH_BITS,
    parameter int KEY_POINT_BYTES   = xder_pkg::DEF_KEY_POINT_BYTES,
    parameter int MAX_LENGTH_OCTETS = xder_pkg::DEF_MAX_LENGTH_OCTETS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_is_status,
    output logic [7:0]       o_key_byte,
    output logic [6:0]       o_key_index,
    output logic [2:0]       o_status,
    output logic             o_end_of_run
);

    xder_pkg::t_push   push;
    xder_pkg::t_result res;
    logic              room;
    logic              fire;

    assign o_stall = !room;
    assign fire    = i_valid && room;

    // Byte parser.
    xder_parser #(
        .LENGTH_BITS       (LENGTH_BITS),
        .KEY_POINT_BYTES   (KEY_POINT_BYTES),
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    // Result queue.
    xder_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (res)
    );

    assign o_is_status  = res.is_status;
    assign o_key_byte   = res.key_byte;
    assign o_key_index  = res.key_index;
    assign o_status     = res.status;
    assign o_end_of_run = res.end_of_run;

endmodule

`default_nettype wire

// ===== rtl/xder_parser.sv =====
`default_nettype none

module xder_parser #(
    parameter int LENGTH_BITS       = xder_pkg::DEF_LENGTH_BITS,
    parameter int KEY_POINT_BYTES   = xder_pkg::DEF_KEY_POINT_BYTES,
    parameter int MAX_LENGTH_OCTETS = xder_pkg::DEF_MAX_LENGTH_OCTETS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output xder_pkg::t_push      o_push
);

    localparam int KPW = $clog2(KEY_POINT_BYTES + 2);

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [KPW-1:0]         t_kpos;

    typedef enum logic [3:0] {
        P_OUTER, P_TBS, P_VER, P_SERIAL, P_TBSSEQ, P_SPKI, P_SPKI_ALG,
        P_KEY, P_EXT, P_SIGALG, P_SIGBITS, P_DONE, P_ERR
    } t_phase;

    typedef enum logic [1:0] {
        S_TAG, S_LEN1, S_LENX, S_BODY
    } t_hdr;

    // Expected tag of each element slot.
    function automatic logic [7:0] tag_of(input t_phase ph);
        logic [7:0] t;
        unique case (ph)
            P_VER:              t = xder_pkg::TAG_CTX0;
            P_SERIAL:           t = xder_pkg::TAG_INT;
            P_KEY, P_SIGBITS:   t = xder_pkg::TAG_BITS;
            P_EXT:              t = xder_pkg::TAG_CTX3;
            default:            t = xder_pkg::TAG_SEQ;
        endcase
        return t;
    endfunction

    // Number of enclosing containers of each slot.
    function automatic logic [1:0] depth_of(input t_phase ph);
        logic [1:0] d;
        unique case (ph)
            P_TBS, P_SIGALG, P_SIGBITS:                   d = 2'd1;
            P_VER, P_SERIAL, P_TBSSEQ, P_SPKI, P_EXT:     d = 2'd2;
            P_SPKI_ALG, P_KEY:                            d = 2'd3;
            default:                                      d = 2'd0;
        endcase
        return d;
    endfunction

    // Bytes left in the innermost container at a given depth.
    function automatic t_len encl(input logic [1:0] d, input t_len a, input t_len b,
                                  input t_len c);
        t_len v;
        unique case (d)
            2'd1:    v = a;
            2'd2:    v = b;
            2'd3:    v = c;
            default: v = '0;
        endcase
        return v;
    endfunction

    t_phase              r_phase, n_phase;
    t_hdr                r_hdr, n_hdr;
    t_len                r_lvl0, n_lvl0;
    t_len                r_lvl1, n_lvl1;
    t_len                r_lvl2, n_lvl2;
    t_len                r_elem, n_elem;
    t_len                r_acc, n_acc;
    logic                r_ovf, n_ovf;
    xder_pkg::t_octets   r_olft, n_olft;
    xder_pkg::t_tbs_count r_tcnt, n_tcnt;
    t_kpos               r_kpos, n_kpos;
    xder_pkg::t_status   r_err, n_err;

    xder_pkg::t_status   fcode;
    xder_pkg::t_status   stat;
    logic                do_len;
    logic                do_leaf;
    logic                do_settle;
    t_len                len;
    logic [6:0]          cnt;
    logic [1:0]          dep;

    // Next-state logic for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_lvl0    = r_lvl0;
        n_lvl1    = r_lvl1;
        n_lvl2    = r_lvl2;
        n_elem    = r_elem;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_olft    = r_olft;
        n_tcnt    = r_tcnt;
        n_kpos    = r_kpos;
        n_err     = r_err;
        o_push    = '0;
        fcode     = xder_pkg::ST_OK;
        stat      = xder_pkg::ST_OK;
        do_len    = 1'b0;
        do_leaf   = 1'b0;
        do_settle = 1'b0;
        len       = '0;
        cnt       = '0;
        dep       = depth_of(r_phase);

        if (i_fire) begin
            if (r_phase < P_DONE) begin
                // The byte must fit in every enclosing container.
                if (dep != 2'd0 && encl(dep, r_lvl0, r_lvl1, r_lvl2) == '0) begin
                    fcode = xder_pkg::ST_SIZE;
                end else begin
                    if (dep >= 2'd1) n_lvl0 = t_len'(r_lvl0 - 1'b1);
                    if (dep >= 2'd2) n_lvl1 = t_len'(r_lvl1 - 1'b1);
                    if (dep >= 2'd3) n_lvl2 = t_len'(r_lvl2 - 1'b1);

                    unique case (r_hdr)
                        S_TAG: begin
                            if (r_phase == P_VER && i_data_byte == xder_pkg::TAG_INT) begin
                                n_phase = P_SERIAL;
                                n_hdr   = S_LEN1;
                            end else if (i_data_byte != tag_of(r_phase)) begin
                                fcode = xder_pkg::ST_TAG;
                            end else begin
                                n_hdr = S_LEN1;
                            end
                        end
                        S_LEN1: begin
                            if (!i_data_byte[7]) begin
                                len    = t_len'(i_data_byte);
                                do_len = 1'b1;
                            end else begin
                                cnt = i_data_byte[6:0];
                                if (cnt == 7'd0 || int'(cnt) > MAX_LENGTH_OCTETS) begin
                                    fcode = xder_pkg::ST_LEN;
                                end else begin
                                    n_olft = xder_pkg::t_octets'(cnt);
                                    n_acc  = '0;
                                    n_ovf  = 1'b0;
                                    n_hdr  = S_LENX;
                                end
                            end
                        end
                        S_LENX: begin
                            n_ovf  = r_ovf | (r_acc[LENGTH_BITS-1 -: 8] != 8'd0);
                            n_acc  = t_len'({r_acc, i_data_byte});
                            n_olft = xder_pkg::t_octets'(r_olft - 1'b1);
                            if (n_olft == '0) begin
                                if (n_ovf) begin
                                    fcode = xder_pkg::ST_LEN;
                                end else begin
                                    len    = n_acc;
                                    do_len = 1'b1;
                                end
                            end
                        end
                        S_BODY: begin
                            if (r_elem == '0) begin
                                fcode = xder_pkg::ST_SIZE;
                            end else begin
                                n_elem = t_len'(r_elem - 1'b1);
                                if (r_phase == P_KEY) begin
                                    if (r_kpos == '0 && i_data_byte != 8'd0) begin
                                        fcode = xder_pkg::ST_KEY;
                                    end else if (r_kpos == t_kpos'(1)
                                                 && i_data_byte != xder_pkg::POINT_FORM) begin
                                        fcode = xder_pkg::ST_KEY;
                                    end else begin
                                        if (r_kpos != '0) begin
                                            o_push.key_vld          = 1'b1;
                                            o_push.key.key_byte     = i_data_byte;
                                            o_push.key.key_index    =
                                                xder_pkg::t_key_index'(t_kpos'(r_kpos - 1'b1));
                                        end
                                        n_kpos = t_kpos'(r_kpos + 1'b1);
                                    end
                                end
                                if (fcode == xder_pkg::ST_OK && n_elem == '0) begin
                                    do_leaf = 1'b1;
                                end
                            end
                        end
                    endcase
                end

                // A complete length field: open a container or start a leaf body.
                if (do_len && fcode == xder_pkg::ST_OK) begin
                    if (dep != 2'd0 && len > encl(dep, n_lvl0, n_lvl1, n_lvl2)) begin
                        fcode = xder_pkg::ST_SIZE;
                    end else if (n_phase == P_OUTER) begin
                        n_lvl0    = len;
                        n_phase   = P_TBS;
                        do_settle = 1'b1;
                    end else if (n_phase == P_TBS) begin
                        n_lvl1    = len;
                        n_phase   = P_VER;
                        do_settle = 1'b1;
                    end else if (n_phase == P_SPKI) begin
                        n_lvl2    = len;
                        n_phase   = P_SPKI_ALG;
                        do_settle = 1'b1;
                    end else if (n_phase == P_KEY
                                 && len != t_len'(KEY_POINT_BYTES + 1)) begin
                        fcode = xder_pkg::ST_KEY;
                    end else begin
                        n_elem = len;
                        n_kpos = '0;
                        n_hdr  = S_BODY;
                        if (len == '0) do_leaf = 1'b1;
                    end
                end

                // End of a leaf element: move on to the next slot.
                if (do_leaf && fcode == xder_pkg::ST_OK) begin
                    do_settle = 1'b1;
                    unique case (n_phase)
                        P_VER: n_phase = P_SERIAL;
                        P_SERIAL: begin
                            n_phase = P_TBSSEQ;
                            n_tcnt  = '0;
                        end
                        P_TBSSEQ: begin
                            n_tcnt = xder_pkg::t_tbs_count'(r_tcnt + 1'b1);
                            if (n_tcnt >= xder_pkg::TBS_SEQ_COUNT) n_phase = P_SPKI;
                        end
                        P_SPKI_ALG: n_phase = P_KEY;
                        P_KEY: begin
                            if (n_lvl2 != '0) fcode = xder_pkg::ST_SIZE;
                            else n_phase = P_EXT;
                        end
                        P_EXT: begin
                            if (n_lvl1 != '0) fcode = xder_pkg::ST_SIZE;
                            else n_phase = P_SIGALG;
                        end
                        P_SIGALG: n_phase = P_SIGBITS;
                        P_SIGBITS: begin
                            do_settle = 1'b0;
                            if (n_lvl0 != '0) begin
                                fcode = xder_pkg::ST_SIZE;
                            end else begin
                                n_phase = P_DONE;
                                n_hdr   = S_TAG;
                            end
                        end
                        default: fcode = xder_pkg::ST_SIZE;
                    endcase
                end

                // Back to a tag; skip the optional [3] when the tbs is used up.
                if (do_settle && fcode == xder_pkg::ST_OK) begin
                    n_hdr = S_TAG;
                    if (n_phase == P_EXT && n_lvl1 == '0) n_phase = P_SIGALG;
                    if (n_phase < P_DONE) begin
                        dep = depth_of(n_phase);
                        if (dep != 2'd0 && encl(dep, n_lvl0, n_lvl1, n_lvl2) == '0) begin
                            fcode = xder_pkg::ST_SIZE;
                        end
                    end
                end
            end else if (r_phase == P_DONE) begin
                // A byte after the outer element has closed.
                fcode = xder_pkg::ST_SIZE;
            end

            if (fcode != xder_pkg::ST_OK) begin
                if (n_err == xder_pkg::ST_OK) n_err = fcode;
                n_phase = P_ERR;
            end

            if (n_phase == P_DONE && !i_last_byte) begin
                if (n_err == xder_pkg::ST_OK) n_err = xder_pkg::ST_SIZE;
                n_phase = P_ERR;
            end

            // Final byte: report the status and return to the start.
            if (i_last_byte) begin
                stat = n_err;
                if (stat == xder_pkg::ST_OK && n_phase != P_DONE) stat = xder_pkg::ST_TRUNC;
                o_push.stat_vld        = 1'b1;
                o_push.stat.is_status  = 1'b1;
                o_push.stat.status     = stat;
                o_push.stat.end_of_run = 1'b1;
                n_phase = P_OUTER;
                n_hdr   = S_TAG;
                n_lvl0  = '0;
                n_lvl1  = '0;
                n_lvl2  = '0;
                n_elem  = '0;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_olft  = '0;
                n_tcnt  = '0;
                n_kpos  = '0;
                n_err   = xder_pkg::ST_OK;
            end
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_OUTER;
            r_hdr   <= S_TAG;
            r_lvl0  <= '0;
            r_lvl1  <= '0;
            r_lvl2  <= '0;
            r_elem  <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_olft  <= '0;
            r_tcnt  <= '0;
            r_kpos  <= '0;
            r_err   <= xder_pkg::ST_OK;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_lvl0  <= n_lvl0;
            r_lvl1  <= n_lvl1;
            r_lvl2  <= n_lvl2;
            r_elem  <= n_elem;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_olft  <= n_olft;
            r_tcnt  <= n_tcnt;
            r_kpos  <= n_kpos;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/xder_result_fifo.sv =====
`default_nettype none

module xder_result_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  xder_pkg::t_push        i_push,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output xder_pkg::t_result      o_result
);

    localparam int PW = $clog2(xder_pkg::RES_FIFO_DEPTH);
    localparam int CW = $clog2(xder_pkg::RES_FIFO_DEPTH + 1);

    typedef logic [PW-1:0] t_ptr;
    typedef logic [CW-1:0] t_count;

    xder_pkg::t_result r_mem [xder_pkg::RES_FIFO_DEPTH];
    t_ptr              r_wr, n_wr;
    t_ptr              r_rd, n_rd;
    t_count            r_count, n_count;
    t_ptr              stat_addr;
    logic              pop;

    // Room for the two words one byte can produce.
    assign o_room   = (int'(r_count) <= xder_pkg::RES_FIFO_DEPTH - 2);
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;

    // The status word goes behind the key word when both arrive together.
    assign stat_addr = i_push.key_vld ? t_ptr'(r_wr + 1'b1) : r_wr;

    always_comb begin
        n_wr    = t_ptr'(r_wr + t_ptr'(i_push.key_vld) + t_ptr'(i_push.stat_vld));
        n_rd    = pop ? t_ptr'(r_rd + 1'b1) : r_rd;
        n_count = t_count'(r_count + t_count'(i_push.key_vld) + t_count'(i_push.stat_vld)
                           - t_count'(pop));
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Stored words.
    always_ff @(posedge i_clk) begin
        if (i_push.key_vld) r_mem[r_wr] <= i_push.key;
        if (i_push.stat_vld) r_mem[stat_addr] <= i_push.stat;
    end

endmodule

`default_nettype wire

// ===== bench/tb_x509_der_public_key_extractor_core.sv =====
`timescale 1ns / 100ps

module tb_x509_der_public_key_extractor_core;

    localparam int LEN_W          = xder_pkg::DEF_LENGTH_BITS;
    localparam int KEY_BYTES      = xder_pkg::DEF_KEY_POINT_BYTES;
    localparam int MAX_OCTETS     = xder_pkg::DEF_MAX_LENGTH_OCTETS;
    localparam int KEY_STR_LEN    = KEY_BYTES + 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 100;
    localparam int ITEMS_PER_MIX  = 200;

    localparam logic [7:0] LEN_LONG = 8'h80;

    // Header slots of the generated certificate, used to pick length forms.
    localparam int H_OUTER   = 0;
    localparam int H_TBS     = 1;
    localparam int H_VER     = 2;
    localparam int H_SER     = 3;
    localparam int H_SEQ     = 4;
    localparam int H_SPKI    = 9;
    localparam int H_ALG     = 10;
    localparam int H_KEY     = 11;
    localparam int H_EXT     = 12;
    localparam int H_SIGALG  = 13;
    localparam int H_SIGBITS = 14;
    localparam int H_COUNT   = 15;

    typedef enum logic [3:0] {
        PH_OUTER, PH_TBS, PH_VER, PH_SERIAL, PH_TBSSEQ, PH_SPKI, PH_SPKI_ALG,
        PH_KEY, PH_EXT, PH_SIGALG, PH_SIGBITS, PH_DONE, PH_ERR
    } t_phase;

    typedef enum logic [1:0] {HS_TAG, HS_LEN1, HS_LENX, HS_BODY} t_hdr;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_is_status;
    logic [7:0] o_key_byte;
    logic [6:0] o_key_index;
    logic [2:0] o_status;
    logic       o_end_of_run;

    x509_der_public_key_extractor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_is_status (o_is_status),
        .o_key_byte  (o_key_byte),
        .o_key_index (o_key_index),
        .o_status    (o_status),
        .o_end_of_run(o_end_of_run)
    );

    // Parser state of the predictor.
    t_phase            ph;
    t_hdr              hdr_step;
    logic [LEN_W-1:0]  lvl_left [3];
    logic [LEN_W-1:0]  elem_left;
    logic [LEN_W-1:0]  len_acc;
    logic              len_ovf;
    logic [3:0]        oct_left;
    logic [2:0]        seq_count;
    logic [6:0]        key_pos;
    xder_pkg::t_status cert_err;

    xder_pkg::t_result words_due [$];
    logic [7:0]        cert_bytes [$];
    bit                long_form [H_COUNT];
    int                pad_zeros [H_COUNT];

    int send_gap_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int words_checked = 0;
    int key_words_checked = 0;
    int status_tally [6];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor of the DER walk.
    // ------------------------------------------------------------------

    function automatic logic [7:0] phase_tag(t_phase p);
        case (p)
            PH_VER:     return xder_pkg::TAG_CTX0;
            PH_SERIAL:  return xder_pkg::TAG_INT;
            PH_KEY:     return xder_pkg::TAG_BITS;
            PH_EXT:     return xder_pkg::TAG_CTX3;
            PH_SIGBITS: return xder_pkg::TAG_BITS;
            default:    return xder_pkg::TAG_SEQ;
        endcase
    endfunction

    function automatic int phase_depth(t_phase p);
        case (p)
            PH_TBS, PH_SIGALG, PH_SIGBITS:             return 1;
            PH_VER, PH_SERIAL, PH_TBSSEQ, PH_SPKI, PH_EXT: return 2;
            PH_SPKI_ALG, PH_KEY:                        return 3;
            default:                                    return 0;
        endcase
    endfunction

    // Containers whose length is tracked, and the element that opens inside.
    function automatic int phase_level(t_phase p);
        case (p)
            PH_OUTER: return 0;
            PH_TBS:   return 1;
            PH_SPKI:  return 2;
            default:  return -1;
        endcase
    endfunction

    function automatic t_phase phase_child(t_phase p);
        case (p)
            PH_OUTER: return PH_TBS;
            PH_TBS:   return PH_VER;
            PH_SPKI:  return PH_SPKI_ALG;
            default:  return PH_ERR;
        endcase
    endfunction

    function automatic void clear_parser();
        ph = PH_OUTER;
        hdr_step = HS_TAG;
        for (int i = 0; i < 3; i++) begin
            lvl_left[i] = '0;
        end
        elem_left = '0;
        len_acc = '0;
        len_ovf = 1'b0;
        oct_left = '0;
        seq_count = '0;
        key_pos = '0;
        cert_err = xder_pkg::ST_OK;
    endfunction

    // The first error wins; everything after it is swallowed.
    function automatic void mark_error(xder_pkg::t_status code);
        if (cert_err == xder_pkg::ST_OK) begin
            cert_err = code;
        end
        ph = PH_ERR;
    endfunction

    function automatic void push_word(logic is_stat, logic [7:0] kb, logic [6:0] ki,
                                      xder_pkg::t_status st, logic eor);
        xder_pkg::t_result w;
        w.is_status = is_stat;
        w.key_byte = kb;
        w.key_index = ki;
        w.status = st;
        w.end_of_run = eor;
        words_due.push_back(w);
    endfunction

    // Moves on to the next header; a required element with no room left is
    // a size error.
    function automatic void enter_next_element();
        int d;
        hdr_step = HS_TAG;
        if (ph == PH_EXT && lvl_left[1] == 0) begin
            ph = PH_SIGALG;
        end
        if (ph < PH_DONE) begin
            d = phase_depth(ph);
            if (d > 0 && lvl_left[d-1] == 0) begin
                mark_error(xder_pkg::ST_SIZE);
            end
        end
    endfunction

    // A leaf element has been consumed completely.
    function automatic void close_leaf();
        case (ph)
            PH_VER: begin
                ph = PH_SERIAL;
            end
            PH_SERIAL: begin
                ph = PH_TBSSEQ;
                seq_count = '0;
            end
            PH_TBSSEQ: begin
                seq_count = seq_count + 3'd1;
                if (seq_count >= xder_pkg::TBS_SEQ_COUNT) begin
                    ph = PH_SPKI;
                end
            end
            PH_SPKI_ALG: begin
                ph = PH_KEY;
            end
            PH_KEY: begin
                if (lvl_left[2] != 0) begin
                    mark_error(xder_pkg::ST_SIZE);
                    return;
                end
                ph = PH_EXT;
            end
            PH_EXT: begin
                if (lvl_left[1] != 0) begin
                    mark_error(xder_pkg::ST_SIZE);
                    return;
                end
                ph = PH_SIGALG;
            end
            PH_SIGALG: begin
                ph = PH_SIGBITS;
            end
            PH_SIGBITS: begin
                if (lvl_left[0] != 0) begin
                    mark_error(xder_pkg::ST_SIZE);
                    return;
                end
                ph = PH_DONE;
                hdr_step = HS_TAG;
                return;
            end
            default: begin
                mark_error(xder_pkg::ST_SIZE);
                return;
            end
        endcase
        enter_next_element();
    endfunction

    function automatic void take_length(logic [LEN_W-1:0] len);
        int d;
        int k;
        d = phase_depth(ph);
        k = phase_level(ph);
        if (d > 0 && len > lvl_left[d-1]) begin
            mark_error(xder_pkg::ST_SIZE);
            return;
        end
        if (k >= 0) begin
            lvl_left[k] = len;
            ph = phase_child(ph);
            enter_next_element();
            return;
        end
        if (ph == PH_KEY && len != KEY_STR_LEN) begin
            mark_error(xder_pkg::ST_KEY);
            return;
        end
        elem_left = len;
        key_pos = '0;
        hdr_step = HS_BODY;
        if (len == 0) begin
            close_leaf();
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int d;
        d = phase_depth(ph);
        // Every enclosing container pays for this byte.
        if (d > 0) begin
            if (lvl_left[d-1] == 0) begin
                mark_error(xder_pkg::ST_SIZE);
                return;
            end
            for (int i = 0; i < d; i++) begin
                lvl_left[i] = lvl_left[i] - 1'b1;
            end
        end
        case (hdr_step)
            HS_TAG: begin
                if (ph == PH_VER && b == xder_pkg::TAG_INT) begin
                    ph = PH_SERIAL;
                end else if (b != phase_tag(ph)) begin
                    mark_error(xder_pkg::ST_TAG);
                    return;
                end
                hdr_step = HS_LEN1;
            end
            HS_LEN1: begin
                if ((b & LEN_LONG) == 0) begin
                    take_length(LEN_W'(b));
                end else begin
                    if (b[6:0] == 0 || b[6:0] > MAX_OCTETS) begin
                        mark_error(xder_pkg::ST_LEN);
                        return;
                    end
                    oct_left = b[3:0];
                    len_acc = '0;
                    len_ovf = 1'b0;
                    hdr_step = HS_LENX;
                end
            end
            HS_LENX: begin
                if (len_acc[LEN_W-1 -: 8] != 0) begin
                    len_ovf = 1'b1;
                end
                len_acc = {len_acc[LEN_W-9:0], b};
                oct_left = oct_left - 4'd1;
                if (oct_left == 0) begin
                    if (len_ovf) begin
                        mark_error(xder_pkg::ST_LEN);
                        return;
                    end
                    take_length(len_acc);
                end
            end
            default: begin
                if (elem_left == 0) begin
                    mark_error(xder_pkg::ST_SIZE);
                    return;
                end
                elem_left = elem_left - 1'b1;
                // The key string opens with 00 04; from the 04 on, every byte
                // is a point byte.
                if (ph == PH_KEY) begin
                    if (key_pos == 0 && b != 8'h00) begin
                        mark_error(xder_pkg::ST_KEY);
                        return;
                    end
                    if (key_pos == 1 && b != xder_pkg::POINT_FORM) begin
                        mark_error(xder_pkg::ST_KEY);
                        return;
                    end
                    if (key_pos >= 1) begin
                        push_word(1'b0, b, key_pos - 7'd1, xder_pkg::ST_OK, 1'b0);
                    end
                    key_pos = key_pos + 7'd1;
                end
                if (elem_left == 0) begin
                    close_leaf();
                end
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        xder_pkg::t_status st;
        if (ph < PH_DONE) begin
            parse_byte(b);
        end else if (ph == PH_DONE) begin
            mark_error(xder_pkg::ST_SIZE);
        end
        if (ph == PH_DONE && !last) begin
            mark_error(xder_pkg::ST_SIZE);
        end
        if (last) begin
            st = cert_err;
            if (st == xder_pkg::ST_OK && ph != PH_DONE) begin
                st = xder_pkg::ST_TRUNC;
            end
            push_word(1'b1, 8'h00, 7'd0, st, 1'b1);
            status_tally[st]++;
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result comparison.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] due,
                               input logic [7:0] seen);
        if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $error("%s: expected %0h, got %0h", name, due, seen);
            end
        end
    endtask

    task automatic check_word();
        xder_pkg::t_result w;
        if (words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $error("result word with nothing expected: status flag %0b, byte %0h",
                       o_is_status, o_key_byte);
            end
        end else begin
            w = words_due.pop_front();
            check_field("is_status", w.is_status, o_is_status);
            check_field("key_byte", w.key_byte, o_key_byte);
            check_field("key_index", w.key_index, o_key_index);
            check_field("status", w.status, o_status);
            check_field("end_of_run", w.end_of_run, o_end_of_run);
            words_checked++;
            if (!w.is_status) begin
                key_words_checked++;
            end
        end
    endtask

    // Both handshakes are observed at the clock edge: bytes feed the
    // predictor first, then the outgoing word is compared.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            predict_byte(i_data_byte, i_last_byte);
        end
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            check_word();
        end
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    // Random back-pressure from the receiver.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Ends the run if nothing moves for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Offers one word and returns at the edge that takes it, valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    function automatic int len_octets(int n);
        return (n < 256) ? 1 : 2;
    endfunction

    function automatic int hdr_size(int id, int n);
        if (!long_form[id] && n < 128) begin
            return 2;
        end
        return 2 + len_octets(n) + pad_zeros[id];
    endfunction

    // Tag and length, short form or long form with optional leading zeros.
    function automatic void put_header(int id, logic [7:0] tag, int n);
        int cnt;
        logic [31:0] nv;
        cert_bytes.push_back(tag);
        nv = n;
        if (!long_form[id] && n < 128) begin
            cert_bytes.push_back(nv[7:0]);
            return;
        end
        cnt = len_octets(n) + pad_zeros[id];
        cert_bytes.push_back(LEN_LONG | 8'(cnt));
        for (int i = cnt - 1; i >= 0; i--) begin
            cert_bytes.push_back(8'(nv >> (8 * i)));
        end
    endfunction

    function automatic void put_filler(int n);
        for (int i = 0; i < n; i++) begin
            cert_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    // Builds a certificate with random contents; the arguments bend the key
    // string, the number of plain tbs sequences and add stray padding.
    function automatic void build_cert(int key_len, logic [7:0] key_lead,
                                       logic [7:0] key_form, int seq_total,
                                       int spki_pad, int tbs_pad);
        int ver_len;
        int ser_len;
        int alg_len;
        int ext_len;
        int sa_len;
        int sb_len;
        int seq_len [5];
        int spki_len;
        int tbs_len;
        int outer_len;
        cert_bytes.delete();
        for (int i = 0; i < H_COUNT; i++) begin
            long_form[i] = ($urandom_range(3, 0) == 0);
            pad_zeros[i] = $urandom_range(2, 0);
        end
        ver_len = ($urandom_range(1, 0) == 1) ? $urandom_range(3, 0) : -1;
        ser_len = $urandom_range(4, 0);
        for (int i = 0; i < 5; i++) begin
            seq_len[i] = ($urandom_range(39, 0) == 0) ? $urandom_range(270, 128)
                                                      : $urandom_range(3, 0);
        end
        alg_len = $urandom_range(4, 0);
        ext_len = ($urandom_range(1, 0) == 1) ? $urandom_range(3, 0) : -1;
        sa_len = $urandom_range(4, 0);
        sb_len = $urandom_range(4, 0);

        spki_len = hdr_size(H_ALG, alg_len) + alg_len
                 + hdr_size(H_KEY, key_len) + key_len + spki_pad;
        tbs_len = hdr_size(H_SER, ser_len) + ser_len
                + hdr_size(H_SPKI, spki_len) + spki_len + tbs_pad;
        if (ver_len >= 0) begin
            tbs_len += hdr_size(H_VER, ver_len) + ver_len;
        end
        if (ext_len >= 0) begin
            tbs_len += hdr_size(H_EXT, ext_len) + ext_len;
        end
        for (int i = 0; i < seq_total; i++) begin
            tbs_len += hdr_size(H_SEQ + i, seq_len[i]) + seq_len[i];
        end
        outer_len = hdr_size(H_TBS, tbs_len) + tbs_len
                  + hdr_size(H_SIGALG, sa_len) + sa_len
                  + hdr_size(H_SIGBITS, sb_len) + sb_len;

        put_header(H_OUTER, xder_pkg::TAG_SEQ, outer_len);
        put_header(H_TBS, xder_pkg::TAG_SEQ, tbs_len);
        if (ver_len >= 0) begin
            put_header(H_VER, xder_pkg::TAG_CTX0, ver_len);
            put_filler(ver_len);
        end
        put_header(H_SER, xder_pkg::TAG_INT, ser_len);
        put_filler(ser_len);
        for (int i = 0; i < seq_total; i++) begin
            put_header(H_SEQ + i, xder_pkg::TAG_SEQ, seq_len[i]);
            put_filler(seq_len[i]);
        end
        put_header(H_SPKI, xder_pkg::TAG_SEQ, spki_len);
        put_header(H_ALG, xder_pkg::TAG_SEQ, alg_len);
        put_filler(alg_len);
        put_header(H_KEY, xder_pkg::TAG_BITS, key_len);
        for (int i = 0; i < key_len; i++) begin
            if (i == 0) begin
                cert_bytes.push_back(key_lead);
            end else if (i == 1) begin
                cert_bytes.push_back(key_form);
            end else begin
                cert_bytes.push_back(8'($urandom_range(255, 0)));
            end
        end
        put_filler(spki_pad);
        if (ext_len >= 0) begin
            put_header(H_EXT, xder_pkg::TAG_CTX3, ext_len);
            put_filler(ext_len);
        end
        put_filler(tbs_pad);
        put_header(H_SIGALG, xder_pkg::TAG_SEQ, sa_len);
        put_filler(sa_len);
        put_header(H_SIGBITS, xder_pkg::TAG_BITS, sb_len);
        put_filler(sb_len);
    endfunction

    task automatic send_cert();
        int n;
        n = cert_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(cert_bytes[i], i == n - 1);
        end
    endtask

    // A short burst of arbitrary bytes closed by a final byte.
    task automatic send_noise();
        int n;
        logic [7:0] b;
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255, 0));
            if (i == 0 && $urandom_range(1, 0) == 1) begin
                b = xder_pkg::TAG_SEQ;
            end
            send_byte(b, i == n - 1);
        end
    endtask

    // Mostly well-formed certificates, the rest broken in assorted ways.
    task automatic run_cert_mix(input int n_bytes);
        int start_count;
        int pick;
        int key_len;
        logic [7:0] key_lead;
        logic [7:0] key_form;
        int seq_total;
        int spki_pad;
        int tbs_pad;
        int keep;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes) begin
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
                send_noise();
            end else begin
                key_len = KEY_STR_LEN;
                key_lead = 8'h00;
                key_form = xder_pkg::POINT_FORM;
                seq_total = xder_pkg::TBS_SEQ_COUNT;
                spki_pad = 0;
                tbs_pad = 0;
                if (pick >= 80 && pick < 86) begin
                    case ($urandom_range(3, 0))
                        0: key_len = ($urandom_range(1, 0) == 1) ? KEY_STR_LEN + 1
                                                                 : KEY_STR_LEN - 1;
                        1: key_len = $urandom_range(KEY_STR_LEN + 4, 0);
                        2: key_lead = 8'($urandom_range(255, 1));
                        default: begin
                            key_form = 8'($urandom_range(255, 0));
                            if (key_form == xder_pkg::POINT_FORM) begin
                                key_form = key_form ^ 8'h01;
                            end
                        end
                    endcase
                end else if (pick >= 86 && pick < 92) begin
                    seq_total = ($urandom_range(1, 0) == 1)
                              ? xder_pkg::TBS_SEQ_COUNT + 1
                              : xder_pkg::TBS_SEQ_COUNT - 1;
                end else if (pick >= 92) begin
                    if ($urandom_range(1, 0) == 1) begin
                        spki_pad = $urandom_range(3, 1);
                    end else begin
                        tbs_pad = $urandom_range(3, 1);
                    end
                end
                build_cert(key_len, key_lead, key_form, seq_total, spki_pad, tbs_pad);
                if (pick >= 60 && pick < 68) begin
                    // One byte overwritten anywhere.
                    cert_bytes[$urandom_range(cert_bytes.size() - 1, 0)] =
                        8'($urandom_range(255, 0));
                end else if (pick >= 68 && pick < 74) begin
                    // Final byte arrives early.
                    keep = $urandom_range(cert_bytes.size() - 1, 1);
                    while (cert_bytes.size() > keep) begin
                        void'(cert_bytes.pop_back());
                    end
                end else if (pick >= 74 && pick < 80) begin
                    // Trailing bytes beyond the outer element.
                    put_filler($urandom_range(3, 1));
                end
                send_cert();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Short hand-made streams: wrong tags, early ends and length encodings.
    task automatic test_header_checks();
        send_gap_pct = 0;
        stall_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(xder_pkg::TAG_SEQ, 1'b1);
        // Long form with no length octets, then with too many.
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(LEN_LONG, 1'b1);
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(LEN_LONG | 8'd9, 1'b1);
        // Length too wide for the counter.
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(LEN_LONG | 8'd3, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Widest long form with leading zeros, then an early end.
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(LEN_LONG | 8'(MAX_OCTETS), 1'b0);
        for (int i = 0; i < MAX_OCTETS - 1; i++) begin
            send_byte(8'h00, 1'b0);
        end
        send_byte(8'h7F, 1'b1);
        // Inner length larger than what is left of the outer element.
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(xder_pkg::TAG_SEQ, 1'b0);
        send_byte(8'h05, 1'b1);
    endtask

    task automatic test_stream_no_idle();
        send_gap_pct = 0;
        stall_pct = 0;
        run_cert_mix(ITEMS_PER_MIX);
    endtask

    task automatic test_stream_sender_gaps();
        send_gap_pct = 88;
        stall_pct = 0;
        run_cert_mix(ITEMS_PER_MIX);
    endtask

    task automatic test_stream_receiver_stalls();
        send_gap_pct = 0;
        stall_pct = 88;
        run_cert_mix(ITEMS_PER_MIX);
    endtask

    task automatic test_stream_both_idle();
        send_gap_pct = 13;
        stall_pct = 13;
        run_cert_mix(ITEMS_PER_MIX);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        i_stall <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            status_tally[i] = 0;
        end
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_checks();
        test_stream_no_idle();
        test_stream_sender_gaps();
        test_stream_receiver_stalls();
        test_stream_both_idle();
        i_valid <= 1'b0;

        while (words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d bytes: %0d ok, %0d tag, %0d length, ",
                 bytes_sent, status_tally[xder_pkg::ST_OK],
                 status_tally[xder_pkg::ST_TAG], status_tally[xder_pkg::ST_LEN],
                 "%0d size, %0d key form, %0d early end.",
                 status_tally[xder_pkg::ST_SIZE], status_tally[xder_pkg::ST_KEY],
                 status_tally[xder_pkg::ST_TRUNC]);
        $display("Compared %0d result words, %0d of them point bytes; %0d mismatches.",
                 words_checked, key_words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
